// File: design/mbap_pkg.sv
// Shared types and constants for the MBAP stream deframer.
`timescale 1ns / 1ps
`default_nettype none

package mbap_pkg;

    localparam int MaxPdu = 253;
    localparam int HdrLen = 8;
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);
    localparam int FillW  = $clog2(HdrLen);

    localparam logic [15:0] LenMax = 16'(MaxPdu + 1);

    typedef struct packed {
        logic [7:0]  pdu_byte;
        logic [15:0] trans_id;
        logic [7:0]  unit_id;
        logic [7:0]  byte_index;
        logic        last;
        logic        empty_frame;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// File: design/mbap_front.sv
// Front end: header window, header check and body tracking; pushes result words.
`timescale 1ns / 1ps
`default_nettype none

module mbap_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire  [7:0]          data_byte,
    input  wire                 restart,
    input  mbap_pkg::q_stat_t   q_stat,
    output logic                in_stall,
    output logic                push,
    output mbap_pkg::res_t      push_data
);

    localparam int WinN = mbap_pkg::HdrLen - 1;
    localparam logic [mbap_pkg::FillW-1:0] FillFull = mbap_pkg::FillW'(WinN);

    logic [7:0]                win_reg [WinN];
    logic [7:0]                win_next [WinN];
    logic [mbap_pkg::FillW-1:0] fill_reg, fill_next;
    logic                      in_body_reg, in_body_next;
    logic [7:0]                left_reg, left_next;
    logic [7:0]                idx_reg, idx_next;
    logic [15:0]               tid_reg, tid_next;
    logic [7:0]                uid_reg, uid_next;

    logic        accept;
    logic [15:0] proto;
    logic [15:0] len;
    logic        bad_hdr;
    logic        body_last;

    assign in_stall  = q_stat.full;
    assign accept    = in_valid & ~q_stat.full;
    assign proto     = {win_reg[2], win_reg[3]};
    assign len       = {win_reg[4], win_reg[5]};
    assign bad_hdr   = (proto != 16'd0) || (len == 16'd0) || (len > mbap_pkg::LenMax);
    assign body_last = (left_reg <= 8'd1);

    always_comb
    begin
        win_next     = win_reg;
        fill_next    = fill_reg;
        in_body_next = in_body_reg;
        left_next    = left_reg;
        idx_next     = idx_reg;
        tid_next     = tid_reg;
        uid_next     = uid_reg;
        push         = 1'b0;
        push_data    = '0;
        if (accept)
        begin
            priority if (restart)
            begin
                for (int i = 0; i < WinN; i++)
                begin
                    win_next[i] = 8'd0;
                end
                fill_next    = '0;
                in_body_next = 1'b0;
                left_next    = 8'd0;
                idx_next     = 8'd0;
                tid_next     = 16'd0;
                uid_next     = 8'd0;
            end
            else if (in_body_reg)
            begin
                push                  = 1'b1;
                push_data.pdu_byte    = data_byte;
                push_data.trans_id    = tid_reg;
                push_data.unit_id     = uid_reg;
                push_data.byte_index  = idx_reg;
                push_data.last        = body_last;
                push_data.empty_frame = 1'b0;
                if (body_last)
                begin
                    in_body_next = 1'b0;
                    left_next    = 8'd0;
                    idx_next     = 8'd0;
                end
                else
                begin
                    left_next = left_reg - 8'd1;
                    idx_next  = idx_reg + 8'd1;
                end
            end
            else if (fill_reg != FillFull)
            begin
                win_next[fill_reg] = data_byte;
                fill_next          = fill_reg + 1'b1;
            end
            else if (bad_hdr)
            begin
                // resync: drop oldest byte
                for (int i = 0; i < WinN - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[WinN - 1] = data_byte;
                fill_next          = FillFull;
            end
            else
            begin
                tid_next             = {win_reg[0], win_reg[1]};
                uid_next             = win_reg[6];
                push                 = 1'b1;
                push_data.trans_id   = {win_reg[0], win_reg[1]};
                push_data.unit_id    = win_reg[6];
                push_data.byte_index = 8'd0;
                push_data.last       = 1'b1;
                if (len == 16'd1)
                begin
                    push_data.pdu_byte    = 8'd0;
                    push_data.empty_frame = 1'b1;
                    win_next[0]           = data_byte;
                    fill_next             = mbap_pkg::FillW'(1);
                end
                else
                begin
                    push_data.pdu_byte    = data_byte;
                    push_data.empty_frame = 1'b0;
                    push_data.last        = (len == 16'd2);
                    fill_next             = '0;
                    if (len > 16'd2)
                    begin
                        in_body_next = 1'b1;
                        left_next    = 8'(len - 16'd2);
                        idx_next     = 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WinN; i++)
            begin
                win_reg[i] <= 8'd0;
            end
            fill_reg    <= '0;
            in_body_reg <= 1'b0;
            left_reg    <= 8'd0;
            idx_reg     <= 8'd0;
            tid_reg     <= 16'd0;
            uid_reg     <= 8'd0;
        end
        else
        begin
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            in_body_reg <= in_body_next;
            left_reg    <= left_next;
            idx_reg     <= idx_next;
            tid_reg     <= tid_next;
            uid_reg     <= uid_next;
        end
    end

endmodule

`default_nettype wire

// File: design/mbap_queue.sv
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module mbap_queue (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       push,
    input  mbap_pkg::res_t            push_data,
    input  wire                       pop,
    output mbap_pkg::res_t            pop_data,
    output mbap_pkg::q_stat_t         q_stat,
    output logic [mbap_pkg::QCw-1:0]  count
);

    mbap_pkg::res_t              slot_reg [mbap_pkg::QDepth];
    logic [mbap_pkg::QAw-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mbap_pkg::QAw-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mbap_pkg::QCw-1:0]    count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign q_stat.full  = (count_reg == mbap_pkg::QCw'(mbap_pkg::QDepth));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push & ~q_stat.full;
    assign do_pop       = pop & ~q_stat.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];
    assign count        = count_reg;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + mbap_pkg::QCw'(do_push) - mbap_pkg::QCw'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/mbap_back.sv
// Output stage: registered result word with valid/stall handshake.
`timescale 1ns / 1ps
`default_nettype none

module mbap_back (
    input  wire                clk,
    input  wire                rst_n,
    input  mbap_pkg::q_stat_t  q_stat,
    input  mbap_pkg::res_t     q_data,
    output logic               pop,
    input  wire                out_stall,
    output logic               out_valid,
    output mbap_pkg::res_t     out_data
);

    logic            valid_reg, valid_next;
    mbap_pkg::res_t  data_reg;

    assign pop        = ~q_stat.empty & (~valid_reg | ~out_stall);
    assign valid_next = pop | (valid_reg & out_stall);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// File: design/mbap_stream_deframer.sv
// Top level of the MBAP stream deframer: front end, result queue, output stage.
// A result word is held in a queue slot, then in the output register, before it is output.
// Throughput: one byte per cycle; the front end stalls only when the 4-word queue is full.
// Reset: rst_n clears the header window, frame state, queue and output valid at once.
// A restart byte clears the same frame state and gives no result word.
`timescale 1ns / 1ps
`default_nettype none

module mbap_stream_deframer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  data_byte,
    input  wire         restart,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [7:0]  pdu_byte,
    output logic [15:0] trans_id,
    output logic [7:0]  unit_id,
    output logic [7:0]  byte_index,
    output logic        last,
    output logic        empty_frame
);

    logic                       push;
    logic                       pop;
    mbap_pkg::res_t             push_data;
    mbap_pkg::res_t             q_data;
    mbap_pkg::res_t             out_data;
    mbap_pkg::q_stat_t          q_stat;
    logic [mbap_pkg::QCw-1:0]   q_count;

    mbap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .restart   (restart),
        .q_stat    (q_stat),
        .in_stall  (in_stall),
        .push      (push),
        .push_data (push_data)
    );

    mbap_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .q_stat    (q_stat),
        .count     (q_count)
    );

    mbap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_data),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign pdu_byte    = out_data.pdu_byte;
    assign trans_id    = out_data.trans_id;
    assign unit_id     = out_data.unit_id;
    assign byte_index  = out_data.byte_index;
    assign last        = out_data.last;
    assign empty_frame = out_data.empty_frame;

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("push into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= mbap_pkg::QCw'(mbap_pkg::QDepth))
        else $error("queue count out of range");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (q_count == mbap_pkg::QCw'(mbap_pkg::QDepth)))
        else $error("input stall does not track queue full");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_frame) |-> (last && byte_index == 8'd0 && pdu_byte == 8'd0))
        else $error("empty frame word malformed");

endmodule

`default_nettype wire
